### hdl/prfds_pkg.sv
// shared types, codes and width helper of the packet ring fifo
package prfds_pkg;

    // default sizes
    localparam int RING_DEPTH_DEF = 8192;
    localparam int MAX_PACKET_DEF = 1023;
    localparam int MAX_READ_DEF   = 64;

    // fixed field widths
    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 7;
    localparam int STAT_W = 32;

    // request codes
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_DATA   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DROP    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_DISCARD = 2'd3
    } status_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } fsm_state_t;

    // one accepted request
    typedef struct packed {
        op_t               op;
        logic [LEN_W-1:0]  packet_length;
        logic [BYTE_W-1:0] byte_in;
        logic [REQ_W-1:0]  read_count;
    } in_item_t;

    // running statistics
    typedef struct packed {
        logic [STAT_W-1:0] drops;
        logic [STAT_W-1:0] drop_bytes;
        logic [STAT_W-1:0] total_bytes;
        logic [STAT_W-1:0] packets;
        logic [STAT_W-1:0] wraps;
        logic [LEN_W-1:0]  recent_size;
    } stats_t;

    // width of the result tdata, rounded up to whole bytes
    function automatic int out_tdata_w(int depth);
        int lvl_w;
        int raw_w;
        lvl_w = $clog2(depth + 1);
        raw_w = BYTE_W + 2 * lvl_w + 5 * STAT_W + LEN_W;
        return (raw_w + 7) & ~7;
    endfunction

endpackage

### hdl/prfds_ring_mem.sv
// byte ring storage: one write port, one read port with registered data
module prfds_ring_mem #(
    parameter int DEPTH = prfds_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(prfds_pkg::RING_DEPTH_DEF)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [prfds_pkg::BYTE_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [prfds_pkg::BYTE_W-1:0] rdata
);

    logic [prfds_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [prfds_pkg::BYTE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered data, holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/prfds_core.sv
// request sequencer: pointers, admission, statistics and result register
module prfds_core #(
    parameter int RING_DEPTH = prfds_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = prfds_pkg::MAX_PACKET_DEF,
    parameter int MAX_READ   = prfds_pkg::MAX_READ_DEF,
    parameter int PTR_W      = $clog2(prfds_pkg::RING_DEPTH_DEF),
    parameter int LVL_W      = $clog2(prfds_pkg::RING_DEPTH_DEF + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request from the input register
    input  logic                         in_vld,
    input  prfds_pkg::in_item_t          in_item,
    output logic                         in_take,
    // result register
    output logic                         res_vld,
    input  logic                         res_rdy,
    output logic [prfds_pkg::BYTE_W-1:0] res_byte,
    output logic                         res_byte_valid,
    output logic                         res_last,
    output prfds_pkg::status_t           res_status,
    output logic [LVL_W-1:0]             res_level,
    output logic [LVL_W-1:0]             peak_level,
    output prfds_pkg::stats_t            stats,
    // ring memory
    output logic                         mem_we,
    output logic [PTR_W-1:0]             mem_waddr,
    output logic [prfds_pkg::BYTE_W-1:0] mem_wdata,
    output logic                         mem_re,
    output logic [PTR_W-1:0]             mem_raddr,
    input  logic [prfds_pkg::BYTE_W-1:0] mem_rdata
);

    localparam int CNT_W = $clog2(MAX_READ + 1);
    localparam int CMP_W = (LVL_W > prfds_pkg::REQ_W) ? LVL_W : prfds_pkg::REQ_W;
    localparam int FIT_W = ((LVL_W > prfds_pkg::LEN_W) ? LVL_W : prfds_pkg::LEN_W) + 1;

    prfds_pkg::fsm_state_t          state_reg, state_next;
    logic [PTR_W-1:0]               wptr_reg, wptr_next;
    logic [PTR_W-1:0]               rptr_reg, rptr_next;
    logic [LVL_W-1:0]               level_reg, level_next;
    logic [prfds_pkg::LEN_W-1:0]    reserved_reg, reserved_next;
    logic [prfds_pkg::LEN_W-1:0]    discard_reg, discard_next;
    logic [LVL_W-1:0]               peak_reg, peak_next;
    prfds_pkg::stats_t              stats_reg, stats_next;
    logic [CNT_W-1:0]               rem_reg, rem_next;
    logic                           pend_reg, pend_next;
    logic [LVL_W-1:0]               pend_level_reg, pend_level_next;
    logic                           pend_last_reg, pend_last_next;
    logic                           out_vld_reg, out_vld_next;
    logic [prfds_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                           out_bvalid_reg, out_bvalid_next;
    logic                           out_last_reg, out_last_next;
    prfds_pkg::status_t             out_status_reg, out_status_next;
    logic [LVL_W-1:0]               out_level_reg, out_level_next;
    logic                           load_out;

    logic                           out_load_ok;
    logic                           pend_used;
    logic                           issue;
    logic [prfds_pkg::LEN_W-1:0]    len_sat;
    logic [prfds_pkg::STAT_W:0]     total_sum;
    logic [FIT_W-1:0]               fit_sum;
    logic                           no_room;
    logic [CMP_W-1:0]               req_cap;
    logic [CMP_W-1:0]               req_clamp;
    logic [CNT_W-1:0]               read_n;
    logic [LVL_W-1:0]               level_inc;
    logic [PTR_W-1:0]               wptr_inc;
    logic [PTR_W-1:0]               rptr_inc;

    // header arithmetic
    assign len_sat   = (in_item.packet_length > prfds_pkg::LEN_W'(MAX_PACKET))
                     ? prfds_pkg::LEN_W'(MAX_PACKET) : in_item.packet_length;
    assign total_sum = {1'b0, stats_reg.total_bytes} + (prfds_pkg::STAT_W + 1)'(len_sat);
    assign fit_sum   = FIT_W'(level_reg) + FIT_W'(len_sat);
    assign no_room   = fit_sum > FIT_W'(RING_DEPTH);

    // read length clamp
    assign req_cap   = (CMP_W'(in_item.read_count) > CMP_W'(MAX_READ))
                     ? CMP_W'(MAX_READ) : CMP_W'(in_item.read_count);
    assign req_clamp = (req_cap > CMP_W'(level_reg)) ? CMP_W'(level_reg) : req_cap;
    assign read_n    = req_clamp[CNT_W-1:0];

    // pointer and level steps
    assign level_inc = level_reg + 1'b1;
    assign wptr_inc  = (wptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign rptr_inc  = (rptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;

    // result register may take a new value
    assign out_load_ok = !out_vld_reg || res_rdy;
    assign pend_used   = pend_reg && out_load_ok;
    assign issue       = (state_reg == prfds_pkg::S_READ) && (rem_reg != '0)
                      && (!pend_reg || pend_used);

    // next state and outputs
    always_comb begin
        state_next      = state_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        level_next      = level_reg;
        reserved_next   = reserved_reg;
        discard_next    = discard_reg;
        peak_next       = peak_reg;
        stats_next      = stats_reg;
        rem_next        = rem_reg;
        pend_next       = pend_reg;
        pend_level_next = pend_level_reg;
        pend_last_next  = pend_last_reg;
        out_byte_next   = out_byte_reg;
        out_bvalid_next = out_bvalid_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_level_next  = out_level_reg;
        load_out        = 1'b0;
        in_take         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            prfds_pkg::S_IDLE: begin
                if (in_vld && out_load_ok) begin
                    in_take         = 1'b1;
                    out_byte_next   = '0;
                    out_bvalid_next = 1'b0;
                    out_last_next   = 1'b1;
                    out_status_next = prfds_pkg::STAT_OK;
                    case (in_item.op)
                        // header: abandon open packet, admit or drop a new non-empty one
                        prfds_pkg::OP_HEADER: begin
                            load_out       = 1'b1;
                            reserved_next  = '0;
                            discard_next   = '0;
                            out_level_next = level_reg;
                            if (len_sat != '0) begin
                                stats_next.total_bytes = total_sum[prfds_pkg::STAT_W-1:0];
                                if (total_sum[prfds_pkg::STAT_W]) begin
                                    stats_next.wraps = stats_reg.wraps + 1'b1;
                                end
                                stats_next.packets     = stats_reg.packets + 1'b1;
                                stats_next.recent_size = len_sat;
                                if (no_room) begin
                                    stats_next.drops      = stats_reg.drops + 1'b1;
                                    stats_next.drop_bytes = stats_reg.drop_bytes
                                                          + prfds_pkg::STAT_W'(len_sat);
                                    discard_next    = len_sat;
                                    out_status_next = prfds_pkg::STAT_DROP;
                                end else begin
                                    reserved_next = len_sat;
                                end
                            end
                        end
                        // data byte: store into reserved space or discard
                        prfds_pkg::OP_DATA: begin
                            load_out = 1'b1;
                            if (reserved_reg != '0 && level_reg < LVL_W'(RING_DEPTH)) begin
                                mem_we         = 1'b1;
                                wptr_next      = wptr_inc;
                                level_next     = level_inc;
                                reserved_next  = reserved_reg - 1'b1;
                                out_level_next = level_inc;
                                if (level_inc > peak_reg) begin
                                    peak_next = level_inc;
                                end
                            end else begin
                                if (discard_reg != '0) begin
                                    discard_next = discard_reg - 1'b1;
                                end
                                out_status_next = prfds_pkg::STAT_DISCARD;
                                out_level_next  = level_reg;
                            end
                        end
                        // read: single empty result or start the byte stream
                        prfds_pkg::OP_READ: begin
                            if (read_n == '0) begin
                                load_out        = 1'b1;
                                out_level_next  = level_reg;
                                out_status_next = (level_reg == '0) ? prfds_pkg::STAT_EMPTY
                                                                    : prfds_pkg::STAT_OK;
                            end else begin
                                state_next = prfds_pkg::S_READ;
                                rem_next   = read_n;
                            end
                        end
                        // clear pointers, level and counters
                        prfds_pkg::OP_CLEAR: begin
                            load_out       = 1'b1;
                            wptr_next      = '0;
                            rptr_next      = '0;
                            level_next     = '0;
                            reserved_next  = '0;
                            discard_next   = '0;
                            peak_next      = '0;
                            stats_next     = '0;
                            out_level_next = '0;
                        end
                        default: begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            prfds_pkg::S_READ: begin
                // move the fetched byte into the result register
                if (pend_used) begin
                    load_out        = 1'b1;
                    out_byte_next   = mem_rdata;
                    out_bvalid_next = 1'b1;
                    out_last_next   = pend_last_reg;
                    out_status_next = prfds_pkg::STAT_OK;
                    out_level_next  = pend_level_reg;
                end
                // fetch the next byte
                if (issue) begin
                    mem_re          = 1'b1;
                    rptr_next       = rptr_inc;
                    level_next      = level_reg - 1'b1;
                    rem_next        = rem_reg - 1'b1;
                    pend_level_next = level_reg - 1'b1;
                    pend_last_next  = (rem_reg == CNT_W'(1));
                end
                pend_next = issue ? 1'b1 : (pend_used ? 1'b0 : pend_reg);
                if (rem_reg == '0 && (!pend_reg || pend_used)) begin
                    state_next = prfds_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = prfds_pkg::S_IDLE;
            end
        endcase

        out_vld_next = load_out ? 1'b1 : (res_rdy ? 1'b0 : out_vld_reg);
    end

    // control and statistics registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= prfds_pkg::S_IDLE;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            level_reg    <= '0;
            reserved_reg <= '0;
            discard_reg  <= '0;
            peak_reg     <= '0;
            stats_reg    <= '0;
            rem_reg      <= '0;
            pend_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            level_reg    <= level_next;
            reserved_reg <= reserved_next;
            discard_reg  <= discard_next;
            peak_reg     <= peak_next;
            stats_reg    <= stats_next;
            rem_reg      <= rem_next;
            pend_reg     <= pend_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_level_reg <= pend_level_next;
        pend_last_reg  <= pend_last_next;
        out_byte_reg   <= out_byte_next;
        out_bvalid_reg <= out_bvalid_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        out_level_reg  <= out_level_next;
    end

    // memory ports
    assign mem_waddr = wptr_reg;
    assign mem_wdata = in_item.byte_in;
    assign mem_raddr = rptr_reg;

    // statistics change only together with a new result, so they are shown live
    assign res_vld        = out_vld_reg;
    assign res_byte       = out_byte_reg;
    assign res_byte_valid = out_bvalid_reg;
    assign res_last       = out_last_reg;
    assign res_status     = out_status_reg;
    assign res_level      = out_level_reg;
    assign peak_level     = peak_reg;
    assign stats          = stats_reg;

    // a fetched byte is only outstanding during a read
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> state_reg == prfds_pkg::S_READ)
        else $error("fetched byte outstanding outside a read");

    // level and reservation never exceed the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        (FIT_W'(level_reg) + FIT_W'(reserved_reg)) <= FIT_W'(RING_DEPTH))
        else $error("level plus reservation exceeds ring depth");

    // watermark never below the level
    assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= level_reg)
        else $error("watermark below level");

    // no leftover read count once back to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == prfds_pkg::S_IDLE |-> rem_reg == '0)
        else $error("read count left over in idle");

endmodule

### hdl/packet_ring_fifo_with_drop_stats.sv
// top level: input holding register, sequencer, ring memory and result packing
//
// Byte ring FIFO with whole-packet admission and drop statistics.
// Requests enter on the s_axis channel (op in tuser), results leave on m_axis.
// A header, data byte or clear gives one result; a read gives one result per
// byte read (tlast on the final one), or one empty result when nothing is read.
// A request lands in an input register and its result then goes into the output
// register, which drives m_axis_tvalid. Header, data and clear requests run at
// one per cycle while the receiver keeps up and no read runs. A read of n bytes
// passes the input register, the read state change and the registered ring read
// before its first byte reaches the output register, then gives one byte per
// cycle if the receiver keeps up; the input register holds at most one waiting
// request. Reset clears pointers, level, reservation and every counter;
// ring contents are undefined after reset and are never read before written.
// When the receiver stalls, the output register holds its result, the input
// register takes one more request and then s_axis_tready goes low.
// The statistics fields always show the counters as of that result.
module packet_ring_fifo_with_drop_stats #(
    parameter int RING_DEPTH = prfds_pkg::RING_DEPTH_DEF,
    parameter int MAX_PACKET = prfds_pkg::MAX_PACKET_DEF,
    parameter int MAX_READ   = prfds_pkg::MAX_READ_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // packet_length[9:0], byte_in[17:10], read_count[24:18], zero fill
    input  logic [31:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_out, level, high_watermark, drop_count, dropped_bytes, total_bytes,
    // packet_count, total_wraps, last_packet_size, zero fill
    output logic [prfds_pkg::out_tdata_w(RING_DEPTH)-1:0] m_axis_tdata,
    // byte_valid[0], status[2:1]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int LVL_W    = $clog2(RING_DEPTH + 1);
    localparam int TDATA_W  = prfds_pkg::out_tdata_w(RING_DEPTH);
    localparam int RAW_W    = prfds_pkg::BYTE_W + 2 * LVL_W + 5 * prfds_pkg::STAT_W
                            + prfds_pkg::LEN_W;

    logic                         in_vld_reg, in_vld_next;
    prfds_pkg::in_item_t          in_item_reg, in_item_next;
    logic                         in_take;

    logic [prfds_pkg::BYTE_W-1:0] res_byte;
    logic                         res_byte_valid;
    logic                         res_last;
    prfds_pkg::status_t           res_status;
    logic [LVL_W-1:0]             res_level;
    logic [LVL_W-1:0]             peak_level;
    prfds_pkg::stats_t            stats;

    logic                         mem_we;
    logic [PTR_W-1:0]             mem_waddr;
    logic [prfds_pkg::BYTE_W-1:0] mem_wdata;
    logic                         mem_re;
    logic [PTR_W-1:0]             mem_raddr;
    logic [prfds_pkg::BYTE_W-1:0] mem_rdata;
    logic [RAW_W-1:0]             res_raw;

    // input holding register
    assign s_axis_tready = !in_vld_reg || in_take;

    always_comb begin
        in_item_next = in_item_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_vld_next                = 1'b1;
            in_item_next.op            = prfds_pkg::op_t'(s_axis_tuser);
            in_item_next.packet_length = s_axis_tdata[9:0];
            in_item_next.byte_in       = s_axis_tdata[17:10];
            in_item_next.read_count    = s_axis_tdata[24:18];
        end else begin
            in_vld_next = in_take ? 1'b0 : in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    // request sequencer
    prfds_core #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET),
        .MAX_READ   (MAX_READ),
        .PTR_W      (PTR_W),
        .LVL_W      (LVL_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_vld         (in_vld_reg),
        .in_item        (in_item_reg),
        .in_take        (in_take),
        .res_vld        (m_axis_tvalid),
        .res_rdy        (m_axis_tready),
        .res_byte       (res_byte),
        .res_byte_valid (res_byte_valid),
        .res_last       (res_last),
        .res_status     (res_status),
        .res_level      (res_level),
        .peak_level     (peak_level),
        .stats          (stats),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // ring storage
    prfds_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (PTR_W)
    ) u_ring (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result packing, first field lowest
    assign res_raw = {stats.recent_size, stats.wraps, stats.packets, stats.total_bytes,
                      stats.drop_bytes, stats.drops, peak_level, res_level, res_byte};
    assign m_axis_tdata = TDATA_W'(res_raw);
    assign m_axis_tuser = {res_status, res_byte_valid};
    assign m_axis_tlast = res_last;

endmodule

### tb/ring_fifo_checker.sv
`timescale 1ns / 100ps
// result checker: watches both channels, predicts every ring fifo result and compares it
module ring_fifo_checker
    import prfds_pkg::*;
#(
    parameter int OUT_W = 208
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      s_axis_tdata,
    input  logic [1:0]       s_axis_tuser,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic [2:0]       m_axis_tuser,
    input  logic             m_axis_tlast,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output int               fail_count,
    output int               pending
);

    localparam int DEPTH     = RING_DEPTH_DEF;
    localparam int LVL_W     = $clog2(DEPTH + 1);
    localparam int LVL_LO    = BYTE_W;
    localparam int PEAK_LO   = LVL_LO + LVL_W;
    localparam int DROPS_LO  = PEAK_LO + LVL_W;
    localparam int DBYTES_LO = DROPS_LO + STAT_W;
    localparam int TOTAL_LO  = DBYTES_LO + STAT_W;
    localparam int PKTS_LO   = TOTAL_LO + STAT_W;
    localparam int WRAPS_LO  = PKTS_LO + STAT_W;
    localparam int SIZE_LO   = WRAPS_LO + STAT_W;

    // one predicted result
    typedef struct {
        logic [BYTE_W-1:0] byte_out;
        logic              byte_valid;
        logic              is_last;
        status_t           status;
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  peak;
        logic [STAT_W-1:0] drops;
        logic [STAT_W-1:0] drop_bytes;
        logic [STAT_W-1:0] total_bytes;
        logic [STAT_W-1:0] packets;
        logic [STAT_W-1:0] wraps;
        logic [LEN_W-1:0]  last_size;
    } fifo_result_t;

    // shadow copy of the ring and its bookkeeping
    logic [BYTE_W-1:0] ring_copy [DEPTH];
    int unsigned       wr_idx;
    int unsigned       rd_idx;
    int unsigned       fill;
    int unsigned       reserved;
    int unsigned       discard_left;
    int unsigned       peak;
    logic [STAT_W-1:0] drops;
    logic [STAT_W-1:0] drop_bytes;
    logic [STAT_W-1:0] total_bytes;
    logic [STAT_W-1:0] packets;
    logic [STAT_W-1:0] wraps;
    logic [LEN_W-1:0]  recent_size;

    fifo_result_t due_results[$];
    int           errors;

    initial errors = 0;
    assign fail_count = errors;

    // empty ring, zero counters
    function automatic void clear_ring();
        wr_idx       = 0;
        rd_idx       = 0;
        fill         = 0;
        reserved     = 0;
        discard_left = 0;
        peak         = 0;
        drops        = '0;
        drop_bytes   = '0;
        total_bytes  = '0;
        packets      = '0;
        wraps        = '0;
        recent_size  = '0;
    endfunction

    // queue one result carrying the counters as they stand now
    function automatic void push_result(logic [BYTE_W-1:0] b, logic valid, logic is_last,
                                        status_t st);
        fifo_result_t r;
        r.byte_out    = b;
        r.byte_valid  = valid;
        r.is_last     = is_last;
        r.status      = st;
        r.level       = fill[LVL_W-1:0];
        r.peak        = peak[LVL_W-1:0];
        r.drops       = drops;
        r.drop_bytes  = drop_bytes;
        r.total_bytes = total_bytes;
        r.packets     = packets;
        r.wraps       = wraps;
        r.last_size   = recent_size;
        due_results.push_back(r);
    endfunction

    // apply one request to the shadow ring and queue the results it causes
    function automatic void advance_ring(op_t op, logic [LEN_W-1:0] len_in,
                                         logic [BYTE_W-1:0] din, logic [REQ_W-1:0] cnt);
        int unsigned       len;
        logic [STAT_W-1:0] next_total;
        int                n;
        status_t           st;
        logic [BYTE_W-1:0] b;
        case (op)
            OP_HEADER: begin
                len = len_in;
                if (len > MAX_PACKET_DEF)
                    len = MAX_PACKET_DEF;
                // a header always abandons whatever packet was open
                reserved     = 0;
                discard_left = 0;
                st           = STAT_OK;
                if (len != 0) begin
                    next_total = total_bytes + len;
                    if (next_total < total_bytes)
                        wraps = wraps + 1;
                    total_bytes = next_total;
                    packets     = packets + 1;
                    recent_size = len[LEN_W-1:0];
                    if (fill + len > DEPTH) begin
                        drops        = drops + 1;
                        drop_bytes   = drop_bytes + len;
                        discard_left = len;
                        st           = STAT_DROP;
                    end else begin
                        reserved = len;
                    end
                end
                push_result('0, 1'b0, 1'b1, st);
            end
            OP_DATA: begin
                if (reserved != 0 && fill < DEPTH) begin
                    ring_copy[wr_idx] = din;
                    wr_idx = (wr_idx == DEPTH - 1) ? 0 : wr_idx + 1;
                    fill++;
                    reserved--;
                    if (fill > peak)
                        peak = fill;
                    push_result('0, 1'b0, 1'b1, STAT_OK);
                end else begin
                    if (discard_left != 0)
                        discard_left--;
                    push_result('0, 1'b0, 1'b1, STAT_DISCARD);
                end
            end
            OP_READ: begin
                n = cnt;
                if (n > MAX_READ_DEF)
                    n = MAX_READ_DEF;
                if (n > int'(fill))
                    n = fill;
                if (n == 0) begin
                    st = (fill == 0) ? STAT_EMPTY : STAT_OK;
                    push_result('0, 1'b0, 1'b1, st);
                end else begin
                    for (int k = 0; k < n; k++) begin
                        b = ring_copy[rd_idx];
                        rd_idx = (rd_idx == DEPTH - 1) ? 0 : rd_idx + 1;
                        fill--;
                        push_result(b, 1'b1, k + 1 == n, STAT_OK);
                    end
                end
            end
            default: begin
                clear_ring();
                push_result('0, 1'b0, 1'b1, STAT_OK);
            end
        endcase
    endfunction

    // count a mismatch, show the first few
    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("tb: %s mismatch, expected %0h, got %0h", fname, want, got);
        end
    endfunction

    // field by field against the oldest prediction
    function automatic void compare_result(fifo_result_t want);
        check_field("byte_out", want.byte_out, m_axis_tdata[BYTE_W-1:0]);
        check_field("byte_valid", want.byte_valid, m_axis_tuser[0]);
        check_field("last", want.is_last, m_axis_tlast);
        check_field("status", want.status, m_axis_tuser[2:1]);
        check_field("level", want.level, m_axis_tdata[LVL_LO +: LVL_W]);
        check_field("high_watermark", want.peak, m_axis_tdata[PEAK_LO +: LVL_W]);
        check_field("drop_count", want.drops, m_axis_tdata[DROPS_LO +: STAT_W]);
        check_field("dropped_bytes", want.drop_bytes, m_axis_tdata[DBYTES_LO +: STAT_W]);
        check_field("total_bytes", want.total_bytes, m_axis_tdata[TOTAL_LO +: STAT_W]);
        check_field("packet_count", want.packets, m_axis_tdata[PKTS_LO +: STAT_W]);
        check_field("total_wraps", want.wraps, m_axis_tdata[WRAPS_LO +: STAT_W]);
        check_field("last_packet_size", want.last_size, m_axis_tdata[SIZE_LO +: LEN_W]);
    endfunction

    // results are checked before the same edge's request is predicted
    always @(posedge aclk) begin
        fifo_result_t want;
        if (!aresetn) begin
            clear_ring();
            due_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("tb: unexpected result, tdata %0h", m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    compare_result(want);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                advance_ring(op_t'(s_axis_tuser), s_axis_tdata[9:0], s_axis_tdata[17:10],
                             s_axis_tdata[24:18]);
        end
        pending <= due_results.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, request stimulus, receiver back-pressure and verdict
module tb;
    import prfds_pkg::*;

    localparam int OUT_W       = out_tdata_w(RING_DEPTH_DEF);
    localparam int RUN_LIMIT   = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_REQS = 140;

    logic             aclk;
    logic             aresetn;
    logic [31:0]      s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [2:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;

    int   fail_count;
    int   pending;
    int   sent_reqs;
    int   cycle_count;
    logic calm;
    logic hold_req;

    packet_ring_fifo_with_drop_stats dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    ring_fifo_checker #(.OUT_W(OUT_W)) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // offer one request, return at the edge that takes it
    task automatic send_req(input op_t op, input logic [9:0] len, input logic [7:0] data,
                            input logic [6:0] cnt);
        while (!calm && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {7'd0, cnt, data, len};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // header followed by a run of random payload bytes
    task automatic send_packet(input int len, input int n_bytes);
        send_req(OP_HEADER, len[9:0], 8'h00, 7'd0);
        for (int i = 0; i < n_bytes; i++)
            send_req(OP_DATA, 10'd0, 8'($urandom), 7'd0);
    endtask

    // stop offering until every predicted result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // request stimulus and verdict
    initial begin
        int  pick;
        int  len;
        int  n_bytes;
        int  shape;
        bit  paused;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_HEADER;
        calm          <= 1'b0;
        hold_req      <= 1'b0;
        paused = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reads on an empty ring, stray byte, zero-length header
        send_req(OP_READ, 10'd0, 8'h00, 7'd0);
        send_req(OP_READ, 10'd0, 8'h00, 7'd127);
        send_req(OP_DATA, 10'd0, 8'hff, 7'd0);
        send_req(OP_HEADER, 10'd0, 8'h00, 7'd0);
        // largest packet, left unfinished and abandoned by a new header
        send_req(OP_HEADER, 10'd1023, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'hff, 7'd0);
        send_req(OP_DATA, 10'd0, 8'ha5, 7'd0);
        send_req(OP_HEADER, 10'd4, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h5a, 7'd0);
        // zero-length header closes the packet, next byte is discarded
        send_req(OP_HEADER, 10'd0, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h01, 7'd0);
        // zero request on a non-empty ring, partial read, read clamped to level
        send_req(OP_READ, 10'd0, 8'h00, 7'd0);
        send_req(OP_READ, 10'd0, 8'h00, 7'd2);
        send_req(OP_READ, 10'd0, 8'h00, 7'd64);
        // byte beyond the declared length
        send_req(OP_HEADER, 10'd2, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h7f, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h80, 7'd0);
        send_req(OP_DATA, 10'd0, 8'h33, 7'd0);
        send_req(OP_CLEAR, 10'd0, 8'h00, 7'd0);
        send_req(OP_READ, 10'd0, 8'h00, 7'd1);
        send_req(OP_HEADER, 10'd512, 8'h00, 7'd0);
        send_req(OP_DATA, 10'd0, 8'hc3, 7'd0);
        send_req(OP_READ, 10'd0, 8'h00, 7'd64);
        wait_drained();

        // receiver holds off while packets and reads keep coming, so the input stalls
        hold_req <= 1'b1;
        send_packet(6, 6);
        send_req(OP_READ, 10'd0, 8'h00, 7'd4);
        send_packet(5, 3);
        send_req(OP_READ, 10'd0, 8'h00, 7'd64);
        send_packet(3, 3);
        send_req(OP_READ, 10'd0, 8'h00, 7'd100);
        send_req(OP_CLEAR, 10'd0, 8'h00, 7'd0);
        wait_drained();

        // random mix: mostly small packets and reads, some broken packets and noise
        sent_reqs = 0;
        while (sent_reqs < RANDOM_REQS) begin
            if (!paused && sent_reqs >= RANDOM_REQS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            // a stretch with no idling on either side
            calm <= (sent_reqs >= 20 && sent_reqs < 60);
            pick = $urandom_range(99);
            if (pick < 45) begin
                len     = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                n_bytes = len;
                shape   = $urandom_range(9);
                if (shape == 0)
                    n_bytes = $urandom_range(len);
                else if (shape == 1)
                    n_bytes = len + $urandom_range(1, 3);
                send_packet(len, n_bytes);
                sent_reqs += n_bytes + 1;
            end else if (pick < 80) begin
                if ($urandom_range(7) == 0)
                    send_req(OP_READ, 10'd0, 8'h00, 7'($urandom_range(127)));
                else
                    send_req(OP_READ, 10'd0, 8'h00, 7'($urandom_range(16)));
                sent_reqs++;
            end else if (pick < 83) begin
                send_req(OP_CLEAR, 10'd0, 8'h00, 7'd0);
                sent_reqs++;
            end else begin
                send_req(op_t'($urandom_range(3)), 10'($urandom), 8'($urandom),
                         7'($urandom));
                sent_reqs++;
            end
        end
        calm <= 1'b0;

        wait_drained();
        repeat (16) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### packet_ring_fifo_with_drop_stats.f
hdl/prfds_pkg.sv
hdl/prfds_ring_mem.sv
hdl/prfds_core.sv
hdl/packet_ring_fifo_with_drop_stats.sv
tb/ring_fifo_checker.sv
tb/tb.sv
